// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL of the positional array list.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/pal_pkg.sv
// Package of the positional array list: sizes, operation and status codes,
// and the plan that the request checker hands to the top level. No dependencies.
`default_nettype none

package pal_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [MODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOCATE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    status_e             status;
    logic                walk;
    logic [ADDR_W-1:0]   first;
    logic [ADDR_W-1:0]   base;
    logic [CNT_W-1:0]    num;
  } plan_t;

endpackage

`default_nettype wire

// File: rtl/pal_check.sv
// Request checker of the positional array list: range and fullness checks
// and the slot walk (first address, entry count) for one request. Uses pal_pkg.
`default_nettype none

module pal_check (
  input  pal_pkg::op_e                 mode_i,
  input  logic [pal_pkg::POS_W-1:0]    position_i,
  input  logic [pal_pkg::CNT_W-1:0]    count_i,
  output pal_pkg::plan_t               plan_o
);
  import pal_pkg::*;

  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] cap_w;
  logic [CMP_W-1:0] span_w;

  assign pos_w  = CMP_W'(position_i);
  assign cnt_w  = CMP_W'(count_i);
  assign cap_w  = CMP_W'(CAPACITY);
  assign span_w = cnt_w - pos_w + CMP_W'(1);

  always_comb begin
    plan_o        = '0;
    plan_o.status = STAT_OK;
    plan_o.base   = ADDR_W'(pos_w - CMP_W'(1));
    case (mode_i)
      OP_INSERT: begin
        if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
          plan_o.status = STAT_RANGE;
        end else if (cnt_w >= cap_w) begin
          plan_o.status = STAT_FULL;
        end else begin
          plan_o.walk  = 1'b1;
          plan_o.first = ADDR_W'(cnt_w - CMP_W'(1));
          plan_o.num   = CNT_W'(span_w);
        end
      end
      OP_DELETE: begin
        if (pos_w == '0 || pos_w > cnt_w) begin
          plan_o.status = STAT_RANGE;
        end else begin
          plan_o.walk  = 1'b1;
          plan_o.first = ADDR_W'(pos_w - CMP_W'(1));
          plan_o.num   = CNT_W'(span_w);
        end
      end
      OP_LOCATE: begin
        plan_o.walk  = 1'b1;
        plan_o.first = '0;
        plan_o.num   = count_i;
      end
      default: begin
        plan_o.walk = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/positional_array_list.sv
// Top level of the positional array list: slot memory, walk sequencer and
// output register. Uses pal_pkg, pal_check and assert_macros.svh.
//
//   channel   dir  tuser        tdata (lowest bit up)
//   s_axis    in   mode[1:0]    position[6:0], value[38:7], zero pad to 40
//   m_axis    out  status[1:0]  removed_value[31:0], found_position[38:32],
//                               length[45:39], zero pad to 48
//
// One item at a time. Insert and delete walk the entries from position p to
// the list end, locate walks until a match or the list end; errors and clear
// skip the walk. The walk moves one entry per cycle through the memory's
// single read and write ports and then drains the last read.
// Reset clears the entry count; slot contents are never cleared.
// A result waiting on m_axis stalls only the end of the next item.
`default_nettype none
`include "assert_macros.svh"

module positional_array_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // position[6:0], value[38:7]
  input  logic [1:0]  s_axis_tuser_i,   // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // removed_value, found_position, length
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);
  import pal_pkg::*;

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_WALK = 3'b010,
    FSM_FIN  = 3'b100
  } fsm_e;

  fsm_e                   fsm_q, fsm_d;
  op_e                    op_q;
  op_e                    in_mode;
  logic [DATA_WIDTH-1:0]  val_q;
  logic [ADDR_W-1:0]      base_q;
  logic [ADDR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]       rd_left_q, rd_left_d;
  logic                   rd_vld_q;
  logic [ADDR_W-1:0]      rd_addr_q;
  logic [DATA_WIDTH-1:0]  rdata_q;
  logic [CNT_W-1:0]       count_q, count_d;
  status_e                status_q, status_d;
  logic [DATA_WIDTH-1:0]  removed_q, removed_d;
  logic [POS_W-1:0]       found_q, found_d;
  logic                   out_valid_q;
  status_e                out_status_q;
  logic [VAL_W-1:0]       out_removed_q;
  logic [POS_W-1:0]       out_found_q;
  logic [POS_W-1:0]       out_len_q;

  logic [DATA_WIDTH-1:0]  slot_mem [CAPACITY];
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0]  mem_wdata;
  logic                   rd_en;
  logic                   drained;
  logic                   load_in;
  logic                   load_out;
  plan_t                  plan;

  assign in_mode = op_e'(s_axis_tuser_i);

  pal_check u_check (
    .mode_i     (in_mode),
    .position_i (s_axis_tdata_i[6:0]),
    .count_i    (count_q),
    .plan_o     (plan)
  );

  assign s_axis_tready_o = (fsm_q == FSM_IDLE);
  assign drained         = (rd_left_q == '0) && !rd_vld_q;

  always_comb begin
    fsm_d     = fsm_q;
    rd_ptr_d  = rd_ptr_q;
    rd_left_d = rd_left_q;
    count_d   = count_q;
    status_d  = status_q;
    removed_d = removed_q;
    found_d   = found_q;
    mem_we    = 1'b0;
    mem_waddr = rd_addr_q;
    mem_wdata = rdata_q;
    rd_en     = 1'b0;
    load_in   = 1'b0;
    load_out  = 1'b0;
    case (fsm_q)
      FSM_IDLE: begin
        if (s_axis_tvalid_i) begin
          load_in   = 1'b1;
          status_d  = plan.status;
          removed_d = '0;
          found_d   = '0;
          rd_ptr_d  = plan.first;
          rd_left_d = plan.num;
          if (in_mode == OP_CLEAR) begin
            count_d = '0;
          end
          fsm_d = plan.walk ? FSM_WALK : FSM_FIN;
        end
      end
      FSM_WALK: begin
        rd_en = (rd_left_q != '0);
        if (rd_en) begin
          rd_left_d = rd_left_q - CNT_W'(1);
          rd_ptr_d  = (op_q == OP_INSERT) ? rd_ptr_q - ADDR_W'(1) : rd_ptr_q + ADDR_W'(1);
        end
        case (op_q)
          OP_INSERT: begin
            if (rd_vld_q) begin
              mem_we    = 1'b1;
              mem_waddr = rd_addr_q + ADDR_W'(1);
            end else if (drained) begin
              mem_we    = 1'b1;
              mem_waddr = base_q;
              mem_wdata = val_q;
              count_d   = count_q + CNT_W'(1);
              fsm_d     = FSM_FIN;
            end
          end
          OP_DELETE: begin
            if (rd_vld_q) begin
              if (rd_addr_q == base_q) begin
                removed_d = rdata_q;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = rd_addr_q - ADDR_W'(1);
              end
            end else if (drained) begin
              count_d = count_q - CNT_W'(1);
              fsm_d   = FSM_FIN;
            end
          end
          OP_LOCATE: begin
            if (rd_vld_q && rdata_q == val_q) begin
              found_d = POS_W'({1'b0, rd_addr_q}) + POS_W'(1);
              fsm_d   = FSM_FIN;
            end else if (drained) begin
              fsm_d = FSM_FIN;
            end
          end
          default: begin
            fsm_d = FSM_FIN;
          end
        endcase
      end
      FSM_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          fsm_d    = FSM_IDLE;
        end
      end
      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= slot_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= FSM_IDLE;
      rd_left_q   <= '0;
      rd_vld_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q     <= fsm_d;
      rd_left_q <= rd_left_d;
      rd_vld_q  <= rd_en;
      count_q   <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q  <= rd_ptr_d;
    rd_addr_q <= rd_ptr_q;
    status_q  <= status_d;
    removed_q <= removed_d;
    found_q   <= found_d;
    if (load_in) begin
      op_q   <= in_mode;
      val_q  <= DATA_WIDTH'(s_axis_tdata_i[38:7]);
      base_q <= plan.base;
    end
    if (load_out) begin
      out_status_q  <= status_q;
      out_removed_q <= VAL_W'(removed_q);
      out_found_q   <= found_q;
      out_len_q     <= POS_W'(count_q);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {2'b00, out_len_q, out_found_q, out_removed_q};

  `ASSERT_CLK(a_len_step, (count_q != $past(count_q)) && (count_q != '0) |-> (count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1)), "length moved by more than one")
  `ASSERT_CLK(a_rd_in_list, rd_en |-> CNT_W'(rd_ptr_q) < count_q, "slot read beyond the list")
  `ASSERT_CLK(a_wr_in_list, mem_we |-> CNT_W'(mem_waddr) <= count_q, "slot write beyond the list end")

endmodule

`default_nettype wire

// File: test/tb_positional_array_list.sv
// Self-checking testbench for positional_array_list: streams insert, delete, locate and
// clear items with random gaps and stalls and checks every result against a shadow list.
// Depends on pal_pkg and the positional_array_list RTL.
`default_nettype none

module tb_positional_array_list;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  typedef struct {
    op_e         mode;
    logic [6:0]  pos;
    logic [31:0] val;
    bit          drain;
  } req_t;

  typedef struct {
    status_e     status;
    logic [31:0] removed;
    logic [6:0]  found;
    logic [6:0]  length;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;

  req_t        pending_items[$];
  result_t     exp_results[$];
  logic [DATA_WIDTH-1:0] list_mem [CAPACITY];
  int          list_len = 0;
  int          gen_len = 0;
  int          err_cnt = 0;
  logic [31:0] val_pool [16];

  req_t        cur_item;
  bit          drv_busy = 1'b0;
  bit          item_taken = 1'b0;
  bit          res_taken = 1'b0;
  bit          drv_calm = 1'b0;
  bit          rcv_calm = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;

  positional_array_list u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always #5 clk_i = ~clk_i;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  task automatic predict_result(input req_t r);
    result_t e;
    int      p;
    int      k;
    bit      hit;
    e.status  = STAT_OK;
    e.removed = '0;
    e.found   = '0;
    p   = int'(r.pos);
    hit = 1'b0;
    case (r.mode)
      OP_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          e.status = STAT_RANGE;
        end else if (list_len >= CAPACITY) begin
          e.status = STAT_FULL;
        end else begin
          for (k = list_len; k >= p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = r.val[DATA_WIDTH-1:0];
          list_len++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > list_len) begin
          e.status = STAT_RANGE;
        end else begin
          e.removed = list_mem[p-1];
          for (k = p; k < list_len; k++) list_mem[k-1] = list_mem[k];
          list_len--;
        end
      end
      OP_LOCATE: begin
        for (k = 0; k < list_len && !hit; k++) begin
          if (list_mem[k] == r.val[DATA_WIDTH-1:0]) begin
            e.found = 7'(k + 1);
            hit = 1'b1;
          end
        end
      end
      default: list_len = 0;
    endcase
    e.length = 7'(list_len);
    exp_results.push_back(e);
  endtask

  task automatic add_item(input op_e mode, input int pos, input logic [31:0] val,
                          input bit drain = 1'b0);
    req_t r;
    r.mode  = mode;
    r.pos   = 7'(pos);
    r.val   = val;
    r.drain = drain;
    pending_items.push_back(r);
    case (mode)
      OP_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY) gen_len++;
      OP_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
      OP_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 6) return val_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  // Sample both channels; predict on accepted requests, check accepted results.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        predict_result(cur_item);
        item_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        res_taken = 1'b1;
        if (exp_results.size() == 0) begin
          report("unexpected result", m_tdata[31:0], '0);
        end else begin
          e = exp_results.pop_front();
          if (m_tuser != e.status) report("status", 32'(m_tuser), 32'(e.status));
          if (m_tdata[31:0] != e.removed) report("removed_value", m_tdata[31:0], e.removed);
          if (m_tdata[38:32] != e.found) report("found_position", 32'(m_tdata[38:32]),
                                                32'(e.found));
          if (m_tdata[45:39] != e.length) report("length", 32'(m_tdata[45:39]),
                                                 32'(e.length));
        end
      end
    end
  end

  // Request driver: advance on acceptance, insert gaps, hold for drain points.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (item_taken) begin
        item_taken = 1'b0;
        drv_busy   = 1'b0;
        if ($urandom_range(0, 49) == 0) drv_calm = !drv_calm;
        gap_left = drv_calm ? 0 : $urandom_range(0, 5);
      end
      if (!drv_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() != 0) begin
          if (!(pending_items[0].drain && exp_results.size() != 0)) begin
            cur_item = pending_items.pop_front();
            drv_busy = 1'b1;
          end
        end
      end
      s_tvalid <= drv_busy;
      s_tdata  <= {1'b0, cur_item.val, cur_item.pos};
      s_tuser  <= cur_item.mode;
    end
  end

  // Result receiver: stall a random number of cycles after each result.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        res_taken = 1'b0;
        if ($urandom_range(0, 49) == 0) rcv_calm = !rcv_calm;
        stall_left = rcv_calm ? 0 : $urandom_range(0, 5);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int n_rand;
    int kind;
    int i;
    int cnt;
    val_pool[0] = 32'h0000_0000;
    val_pool[1] = 32'hFFFF_FFFF;
    for (i = 2; i < 16; i++) val_pool[i] = $urandom;

    add_item(OP_LOCATE, 0, 32'h0000_0000);
    add_item(OP_DELETE, 1, 32'h0000_0000);
    add_item(OP_INSERT, 0, 32'h1111_1111);
    add_item(OP_INSERT, 2, 32'h2222_2222);
    add_item(OP_INSERT, 127, 32'hFFFF_FFFF);
    add_item(OP_INSERT, 1, 32'h0000_0000);
    add_item(OP_INSERT, 1, 32'hFFFF_FFFF);
    add_item(OP_INSERT, 3, 32'h5555_5555);
    add_item(OP_INSERT, 2, 32'hAAAA_AAAA);
    add_item(OP_INSERT, 5, 32'hAAAA_AAAA);
    add_item(OP_LOCATE, 127, 32'hAAAA_AAAA);
    add_item(OP_LOCATE, 0, 32'hFFFF_FFFF);
    add_item(OP_LOCATE, 3, 32'h1234_5678);
    add_item(OP_DELETE, 0, 32'hFFFF_FFFF);
    add_item(OP_DELETE, 6, 32'h0000_0000);
    add_item(OP_DELETE, 5, 32'h0000_0000);
    add_item(OP_DELETE, 1, 32'h0000_0000, 1'b1);
    add_item(OP_DELETE, 2, 32'h0000_0000);
    add_item(OP_CLEAR, 127, 32'hFFFF_FFFF);
    add_item(OP_LOCATE, 0, 32'h0000_0000);
    add_item(OP_DELETE, 1, 32'h0000_0000);
    add_item(OP_INSERT, 1, 32'h8000_0001);

    n_rand = 0;
    kind   = 5;
    while (n_rand < 1900) begin
      cnt = pending_items.size();
      case (kind)
        0, 1, 2, 3, 4: begin
          for (i = 0; i < 30; i++) begin
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                add_item(OP_INSERT, $urandom_range(1, gen_len + 1), pick_value());
              10, 11, 12, 13, 14:
                add_item(OP_DELETE, gen_len == 0 ? 1 : $urandom_range(1, gen_len), '0);
              15, 16, 17, 18:
                add_item(OP_LOCATE, $urandom_range(0, 127), pick_value());
              default:
                add_item(op_e'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom);
            endcase
          end
        end
        5, 6: begin
          add_item(OP_LOCATE, 0, pick_value(), 1'b1);
          while (gen_len < CAPACITY) add_item(OP_INSERT, $urandom_range(1, gen_len + 1),
                                              pick_value());
          add_item(OP_INSERT, $urandom_range(1, gen_len + 1), pick_value());
          add_item(OP_INSERT, gen_len + 2, pick_value());
          add_item(OP_INSERT, 0, pick_value());
          add_item(OP_LOCATE, $urandom_range(0, 127), pick_value());
          add_item(OP_LOCATE, $urandom_range(0, 127), pick_value());
        end
        7, 8: begin
          while (gen_len > 0) begin
            if ($urandom_range(0, 3) == 0) add_item(OP_LOCATE, 0, pick_value());
            else add_item(OP_DELETE, $urandom_range(1, gen_len), $urandom);
          end
          add_item(OP_DELETE, $urandom_range(0, 2), $urandom);
        end
        default: add_item(OP_CLEAR, $urandom_range(0, 127), $urandom);
      endcase
      n_rand += pending_items.size() - cnt;
      kind = $urandom_range(0, 9);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || drv_busy || exp_results.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && exp_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
